// ----- design/wht_pkg.sv -----
// ----------------------------------------------------------------------------
// wht_pkg
// Shared types and constants for the Walsh-Hadamard transform engine.
// ----------------------------------------------------------------------------
package wht_pkg;

   localparam int LOG_MAX_DEF  = 10;
   localparam int CMD_W        = 2;
   localparam int IDX_W        = 10;
   localparam int DATA_W       = 64;
   localparam int LOG_W        = 4;
   localparam logic [LOG_W-1:0] LOG_SIZE_RST = 4'd10;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE     = 2'd0,
      CMD_TRANSFORM = 2'd1,
      CMD_READ      = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_TF_RD,
      ST_TF_LO,
      ST_TF_HI
   } state_type;

endpackage

// ----- design/wht_if.sv -----
// ----------------------------------------------------------------------------
// wht_if
// Valid/ready channels of the transform engine: command, response and
// configuration write.
// ----------------------------------------------------------------------------
interface wht_req_if
   import wht_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] value;

   modport source (output valid, output command, output index, output value,
                   input ready);
   modport sink   (input valid, input command, input index, input value,
                   output ready);
endinterface

interface wht_rsp_if
   import wht_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              status;

   modport source (output valid, output read_data, output status, input ready);
   modport sink   (input valid, input read_data, input status, output ready);
endinterface

interface wht_csr_if
   import wht_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [LOG_W-1:0] log_size;

   modport source (output valid, output log_size, input ready);
   modport sink   (input valid, input log_size, output ready);
endinterface

// ----- design/walsh_hadamard_transform.sv -----
// ----------------------------------------------------------------------------
// walsh_hadamard_transform
// Write, read and in-place fast Walsh-Hadamard transform over a 64-bit
// vector memory of 2^LOG_MAX words, sums and differences modulo 2^64.
// ----------------------------------------------------------------------------
// Write, unused and out-of-range requests respond directly, a read after the
// memory read register. One write per cycle unless responses stall; nothing is
// taken in a read or transform. Transform: n = min(log_size, LOG_MAX) passes,
// each a read state, then sum and difference writes on the single write port.
// Reset: control state clears and log_size returns to 10; the vector memory
// is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform
   import wht_pkg::*;
#(
   parameter int LOG_MAX = LOG_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wht_req_if.sink    req_chan,
   wht_rsp_if.source  rsp_chan,
   wht_csr_if.sink    csr_chan
);

   localparam int AW    = LOG_MAX;
   localparam int NW    = $clog2(LOG_MAX + 1);
   localparam int DEPTH = 1 << LOG_MAX;

   logic [DATA_W-1:0] mem [DEPTH];

   state_type         state_ff, state_in;
   logic [LOG_W-1:0]  log_size_ff, log_size_in;
   logic [NW-1:0]     pass_ff, pass_in;
   logic [AW-1:0]     pair_ff, pair_in;
   logic [DATA_W-1:0] diff_ff, diff_in;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_status_ff, rsp_status_in;

   logic [NW-1:0]     eff_n;
   logic              idx_oob;
   logic [AW-1:0]     idx_addr;
   logic              req_fire;
   logic              req_ready;
   logic [AW:0]       pair_inc;
   logic [AW-1:0]     pair_nxt;
   logic              last_pair;
   logic              last_pass;
   logic [AW-1:0]     lo_cur, hi_cur, lo_nxt, hi_nxt;
   logic [AW-1:0]     rd_addr_a, rd_addr_b;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rsp_load;
   logic [DATA_W-1:0] rsp_load_data;
   logic              rsp_load_status;

   function automatic logic [AW-1:0] lo_addr(input logic [AW-1:0] k,
                                             input logic [NW-1:0] p);
      logic [AW-1:0] upper;
      logic [AW-1:0] lower_mask;
      upper      = ((k >> p) << p) << 1;
      lower_mask = ~({AW{1'b1}} << p);
      return upper | (k & lower_mask);
   endfunction

   // effective transform size
   always_comb begin
      if (int'(log_size_ff) > LOG_MAX) begin
         eff_n = NW'(LOG_MAX);
      end else begin
         eff_n = NW'(log_size_ff);
      end
   end

   assign idx_oob   = ((req_chan.index >> eff_n) != '0);
   assign idx_addr  = AW'(req_chan.index);
   assign req_fire  = req_chan.valid && req_ready;

   assign pair_inc  = {1'b0, pair_ff} + (AW+1)'(1);
   assign pair_nxt  = pair_inc[AW-1:0];
   assign last_pair = |(pair_inc >> (eff_n - NW'(1)));
   assign last_pass = (pass_ff == (eff_n - NW'(1)));

   assign lo_cur = lo_addr(pair_ff, pass_ff);
   assign hi_cur = lo_cur | (AW'(1) << pass_ff);
   assign lo_nxt = lo_addr(pair_nxt, pass_ff);
   assign hi_nxt = lo_nxt | (AW'(1) << pass_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == CMD_READ && !idx_oob) begin
                  state_in = ST_RD_WAIT;
               end else if (req_chan.command == CMD_TRANSFORM && eff_n != '0) begin
                  state_in = ST_TF_RD;
               end
            end
         end
         ST_RD_WAIT: state_in = ST_IDLE;
         ST_TF_RD:   state_in = ST_TF_LO;
         ST_TF_LO:   state_in = ST_TF_HI;
         ST_TF_HI: begin
            if (!last_pair) begin
               state_in = ST_TF_LO;
            end else if (!last_pass) begin
               state_in = ST_TF_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready       = 1'b0;
      rd_addr_a       = lo_cur;
      rd_addr_b       = hi_cur;
      wr_en           = 1'b0;
      wr_addr         = lo_cur;
      wr_data         = rd_a_ff + rd_b_ff;
      diff_in         = diff_ff;
      pass_in         = pass_ff;
      pair_in         = pair_ff;
      rsp_load        = 1'b0;
      rsp_load_data   = '0;
      rsp_load_status = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_chan.ready;
            rd_addr_a = idx_addr;
            wr_addr   = idx_addr;
            wr_data   = req_chan.value;
            pass_in   = '0;
            pair_in   = '0;
            if (req_fire) begin
               case (req_chan.command)
                  CMD_WRITE: begin
                     wr_en           = !idx_oob;
                     rsp_load        = 1'b1;
                     rsp_load_status = idx_oob;
                  end
                  CMD_READ: begin
                     rsp_load        = idx_oob;
                     rsp_load_status = idx_oob;
                  end
                  CMD_TRANSFORM: begin
                     rsp_load = (eff_n == '0);
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_load      = 1'b1;
            rsp_load_data = rd_a_ff;
         end
         ST_TF_RD: begin
         end
         ST_TF_LO: begin
            wr_en   = 1'b1;
            diff_in = rd_a_ff - rd_b_ff;
         end
         ST_TF_HI: begin
            wr_en     = 1'b1;
            wr_addr   = hi_cur;
            wr_data   = diff_ff;
            rd_addr_a = lo_nxt;
            rd_addr_b = hi_nxt;
            if (!last_pair) begin
               pair_in = pair_nxt;
            end else begin
               pair_in  = '0;
               pass_in  = pass_ff + NW'(1);
               rsp_load = last_pass;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      log_size_in = log_size_ff;
      if (csr_chan.valid) begin
         log_size_in = csr_chan.log_size;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = rsp_load_data;
         rsp_status_in = rsp_load_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         log_size_ff  <= LOG_SIZE_RST;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
         pair_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         log_size_ff  <= log_size_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         pair_ff      <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // vector memory: one write port, two read ports, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign req_chan.ready     = req_ready;
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule
